// File: design/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Needs nothing else; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/mprf_pkg.sv
// Package for the monochrome pattern rectangle fill: widths, clip limits,
// register indexes and raster operation codes. No dependencies.
package mprf_pkg;

   localparam int MAX_WIDTH_PIXELS = 4096;
   localparam int MAX_HEIGHT_ROWS  = 4096;

   localparam int COORD_W     = 12;
   localparam int COL_W       = 9;
   localparam int ROW_W       = 12;
   localparam int BYTE_W      = 8;
   localparam int PAT_W       = 64;
   localparam int PHASE_W     = 3;
   localparam int ROP_W       = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 8;
   localparam int RSP_TUSER_W = 1;
   localparam int CLIP_W      = 17;

   localparam logic [CLIP_W-1:0] MAX_COL = CLIP_W'(MAX_WIDTH_PIXELS - 1);
   localparam logic [CLIP_W-1:0] MAX_ROW = CLIP_W'(MAX_HEIGHT_ROWS - 1);

   localparam logic [CSR_ADDR_W-1:0] CSR_PATTERN_ROWS     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RECT_LEFT        = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RECT_RIGHT       = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RECT_TOP         = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_RECT_BOTTOM      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE_HORIZONTAL = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE_VERTICAL   = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROP_MODE         = 3'd7;

   typedef enum logic [ROP_W-1:0] {
      ROP_COPY  = 2'd0,
      ROP_CLEAR = 2'd1,
      ROP_XOR   = 2'd2,
      ROP_OR    = 2'd3
   } rop_type;

endpackage

// File: design/mono_pattern_rect_fill_rop_top.sv
// Monochrome pattern rectangle fill with raster operation, per-byte datapath.
// Depends on mprf_pkg.
//
// Each request transaction carries one destination byte (its byte column, pixel row
// and old value, pixels MSB first); the block returns the byte after the masked
// raster operation with the phased 8x8 pattern, plus a touched flag. One byte is
// accepted every clock and one result leaves every clock while rsp_tready is high;
// a byte passes the input register, mask and raster logic, then result register.
// The user must write registers through the csr_ port only while no transaction is
// in flight, unchecked; bytes outside the clipped rectangle pass through untouched.
module mono_pattern_rect_fill_rop_top
   import mprf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // byte_column [8:0], pixel_row [20:9], old_byte [28:21], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // new_byte [7:0]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // touched [0]
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [PAT_W-1:0]   pattern_rows_ff;
   logic [COORD_W-1:0] rect_left_ff;
   logic [COORD_W-1:0] rect_right_ff;
   logic [COORD_W-1:0] rect_top_ff;
   logic [COORD_W-1:0] rect_bottom_ff;
   logic [PHASE_W-1:0] phase_horizontal_ff;
   logic [PHASE_W-1:0] phase_vertical_ff;
   rop_type            rop_mode_ff;

   logic               s1_valid_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic [BYTE_W-1:0]  s1_old_ff;

   logic               s2_valid_ff;
   logic [BYTE_W-1:0]  new_byte_ff;
   logic               touched_ff;
   logic [BYTE_W-1:0]  new_byte_in;
   logic               touched_in;

   logic               s2_advance;
   logic               s1_advance;

   logic [CLIP_W-1:0]  l_ext, r_ext, t_ext, b_ext;
   logic [CLIP_W-1:0]  r_clip, b_clip, e_ext, lcol, ecol, col_ext, row_ext;
   logic               in_rect;
   logic [BYTE_W-1:0]  mask;
   logic [PHASE_W-1:0] pat_sel;
   logic [BYTE_W-1:0]  pat_raw;
   logic [2*BYTE_W-1:0] pat_wide;
   logic [BYTE_W-1:0]  pat_masked;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_rows_ff     <= '0;
         rect_left_ff        <= '0;
         rect_right_ff       <= '0;
         rect_top_ff         <= '0;
         rect_bottom_ff      <= '0;
         phase_horizontal_ff <= '0;
         phase_vertical_ff   <= '0;
         rop_mode_ff         <= ROP_COPY;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_PATTERN_ROWS:     pattern_rows_ff     <= csr_wdata;
            CSR_RECT_LEFT:        rect_left_ff        <= csr_wdata[COORD_W-1:0];
            CSR_RECT_RIGHT:       rect_right_ff       <= csr_wdata[COORD_W-1:0];
            CSR_RECT_TOP:         rect_top_ff         <= csr_wdata[COORD_W-1:0];
            CSR_RECT_BOTTOM:      rect_bottom_ff      <= csr_wdata[COORD_W-1:0];
            CSR_PHASE_HORIZONTAL: phase_horizontal_ff <= csr_wdata[PHASE_W-1:0];
            CSR_PHASE_VERTICAL:   phase_vertical_ff   <= csr_wdata[PHASE_W-1:0];
            CSR_ROP_MODE:         rop_mode_ff         <= rop_type'(csr_wdata[ROP_W-1:0]);
            default: ;
         endcase
      end
   end

   assign s2_advance = !s2_valid_ff || rsp_tready;
   assign s1_advance = !s1_valid_ff || s2_advance;
   assign req_tready = s1_advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && req_tvalid) begin
         s1_col_ff <= req_tdata[COL_W-1:0];
         s1_row_ff <= req_tdata[COL_W+ROW_W-1:COL_W];
         s1_old_ff <= req_tdata[COL_W+ROW_W+BYTE_W-1:COL_W+ROW_W];
      end
   end

   // write mask from the clipped rectangle
   always_comb begin
      l_ext   = CLIP_W'(rect_left_ff);
      r_ext   = CLIP_W'(rect_right_ff);
      t_ext   = CLIP_W'(rect_top_ff);
      b_ext   = CLIP_W'(rect_bottom_ff);
      r_clip  = (r_ext > MAX_COL) ? MAX_COL : r_ext;
      b_clip  = (b_ext > MAX_ROW) ? MAX_ROW : b_ext;
      e_ext   = r_clip + CLIP_W'(1);
      lcol    = l_ext >> 3;
      ecol    = e_ext >> 3;
      col_ext = CLIP_W'(s1_col_ff);
      row_ext = CLIP_W'(s1_row_ff);
      in_rect = (l_ext <= MAX_COL) && (t_ext <= MAX_ROW)
             && (r_clip >= l_ext) && (b_clip >= t_ext)
             && (row_ext >= t_ext) && (row_ext <= b_clip)
             && (col_ext >= lcol) && (col_ext <= ecol);
      mask = 8'hff;
      if (col_ext == lcol) begin
         mask = mask & (8'hff >> l_ext[2:0]);
      end
      if (col_ext == ecol) begin
         mask = mask & ~(8'hff >> e_ext[2:0]);
      end
      if (!in_rect) begin
         mask = '0;
      end
   end

   // phased pattern byte
   always_comb begin
      pat_sel    = s1_row_ff[PHASE_W-1:0] + phase_vertical_ff;
      pat_raw    = pattern_rows_ff[BYTE_W*pat_sel +: BYTE_W];
      pat_wide   = {pat_raw, pat_raw} << phase_horizontal_ff;
      pat_masked = pat_wide[2*BYTE_W-1:BYTE_W] & mask;
   end

   always_comb begin
      case (rop_mode_ff)
         ROP_COPY:  new_byte_in = (s1_old_ff & ~mask) | pat_masked;
         ROP_CLEAR: new_byte_in = s1_old_ff & ~pat_masked;
         ROP_XOR:   new_byte_in = s1_old_ff ^ pat_masked;
         default:   new_byte_in = s1_old_ff | pat_masked;
      endcase
      touched_in = |mask;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_advance && s1_valid_ff) begin
         new_byte_ff <= new_byte_in;
         touched_ff  <= touched_in;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = new_byte_ff;
   assign rsp_tuser  = touched_ff;

endmodule

// File: design/mprf_checker.sv
// Port-level checker for mono_pattern_rect_fill_rop_top, bound to the top level.
// Depends on mprf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mprf_checker
   import mprf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser
);

   logic                               req_fire;
   logic                               rsp_stall;
   logic [RSP_TUSER_W+RSP_TDATA_W-1:0] rsp_bits;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_bits  = {rsp_tuser, rsp_tdata};

   `ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid, "rsp_tvalid after reset")
   `ASSERT_AT(a_no_stall_when_drained, clock, reset, rsp_tready |-> req_tready, "input stalled")
   `ASSERT_AT(a_latency, clock, reset, req_fire ##1 rsp_tready |=> rsp_tvalid, "late result")
   `ASSERT_AT(a_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_bits), "result moved")

endmodule

bind mono_pattern_rect_fill_rop_top mprf_checker u_mprf_checker (.*);

// File: test/testbench.sv
// Self-checking bench for mono_pattern_rect_fill_rop_top: directed and random byte
// transactions against a built-in predictor of the masked pattern raster operation.
// Depends on mprf_pkg and the block's top module.
module testbench;
   import mprf_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_ITEMS = 1400;

   typedef struct packed {
      logic [PAT_W-1:0]   pattern;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] bottom;
      logic [PHASE_W-1:0] phase_h;
      logic [PHASE_W-1:0] phase_v;
      rop_type            rop;
   } fill_cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] new_byte;
      logic              touched;
   } fill_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   fill_cfg_type    fill_cfg = '0;
   fill_result_type expected_bytes[$];

   int fail_count      = 0;
   int bytes_sent      = 0;
   int results_checked = 0;
   int touched_count   = 0;
   int settings_used   = 0;
   int burst_left      = 0;
   int quiet_cycles    = 0;
   int stall_left      = 0;
   int stall_tick      = 0;
   logic [1:0] stall_style = 2'd0;

   mono_pattern_rect_fill_rop_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [BYTE_W-1:0] fill_mask(fill_cfg_type c, logic [COL_W-1:0] col,
                                                   logic [ROW_W-1:0] row);
      int l, r, t, b, e, lcol, ecol, cl, rw;
      logic [BYTE_W-1:0] m;
      l  = int'(c.left);
      r  = int'(c.right);
      t  = int'(c.top);
      b  = int'(c.bottom);
      cl = int'(col);
      rw = int'(row);
      if (l > MAX_WIDTH_PIXELS - 1 || t > MAX_HEIGHT_ROWS - 1) return '0;
      if (r > MAX_WIDTH_PIXELS - 1) r = MAX_WIDTH_PIXELS - 1;
      if (b > MAX_HEIGHT_ROWS - 1) b = MAX_HEIGHT_ROWS - 1;
      if (r < l || b < t || rw < t || rw > b) return '0;
      e    = r + 1;
      lcol = l >> 3;
      ecol = e >> 3;
      if (cl < lcol || cl > ecol) return '0;
      m = 8'hff;
      if (cl == lcol) m = m & (8'hff >> (l & 7));
      if (cl == ecol) m = m & ~(8'hff >> (e & 7));
      return m;
   endfunction

   function automatic fill_result_type predict_fill(fill_cfg_type c, logic [COL_W-1:0] col,
                                                    logic [ROW_W-1:0] row,
                                                    logic [BYTE_W-1:0] old);
      fill_result_type res;
      logic [BYTE_W-1:0] m, pat, pm;
      logic [2:0] sel;
      logic [15:0] twice;
      m     = fill_mask(c, col, row);
      sel   = row[2:0] + c.phase_v;
      pat   = c.pattern[8*sel +: 8];
      twice = {pat, pat} << c.phase_h;
      pm    = twice[15:8] & m;
      case (c.rop)
         ROP_COPY:  res.new_byte = (old & ~m) | pm;
         ROP_CLEAR: res.new_byte = old & ~pm;
         ROP_XOR:   res.new_byte = old ^ pm;
         default:   res.new_byte = old | pm;
      endcase
      res.touched = (m != '0);
      return res;
   endfunction

   function automatic fill_cfg_type make_cfg(logic [PAT_W-1:0] pattern, int l, int r, int t,
                                             int b, int ph, int pv, rop_type rop);
      fill_cfg_type c;
      c.pattern = pattern;
      c.left    = COORD_W'(l);
      c.right   = COORD_W'(r);
      c.top     = COORD_W'(t);
      c.bottom  = COORD_W'(b);
      c.phase_h = PHASE_W'(ph);
      c.phase_v = PHASE_W'(pv);
      c.rop     = rop;
      return c;
   endfunction

   task automatic random_span(output int lo, output int hi, input int span);
      case ($urandom_range(0, 9))
         0: begin
            lo = 0;
            hi = 4095;
         end
         1: begin
            lo = $urandom_range(1, 4095);
            hi = $urandom_range(0, lo - 1);
         end
         2: begin
            lo = $urandom_range(0, 4095);
            hi = lo;
         end
         3: begin
            lo = $urandom_range(4000, 4095);
            hi = 4095;
         end
         default: begin
            lo = $urandom_range(0, 4095);
            hi = lo + $urandom_range(0, span);
            if (hi > 4095) hi = 4095;
         end
      endcase
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_fill_cfg(input fill_cfg_type c);
      write_register(CSR_PATTERN_ROWS, c.pattern);
      write_register(CSR_RECT_LEFT, CSR_DATA_W'(c.left));
      write_register(CSR_RECT_RIGHT, CSR_DATA_W'(c.right));
      write_register(CSR_RECT_TOP, CSR_DATA_W'(c.top));
      write_register(CSR_RECT_BOTTOM, CSR_DATA_W'(c.bottom));
      write_register(CSR_PHASE_HORIZONTAL, CSR_DATA_W'(c.phase_h));
      write_register(CSR_PHASE_VERTICAL, CSR_DATA_W'(c.phase_v));
      write_register(CSR_ROP_MODE, CSR_DATA_W'(c.rop));
      csr_we   <= 1'b0;
      fill_cfg  = c;
      settings_used++;
   endtask

   // Hold the sender off until every outstanding result has been checked.
   task automatic drain_fill;
      req_tvalid <= 1'b0;
      burst_left  = 0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_byte(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                            input logic [BYTE_W-1:0] old);
      int gap;
      fill_result_type want;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      want = predict_fill(fill_cfg, col, row, old);
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, old, row, col};
      do @(posedge clock); while (!req_tready);
      expected_bytes.push_back(want);
      bytes_sent++;
   endtask

   task automatic test_reset_state;
      send_byte(9'd0, 12'd0, 8'h00);
      send_byte(9'd0, 12'd0, 8'hff);
      send_byte(9'd1, 12'd0, 8'hff);
      send_byte(9'd0, 12'd1, 8'hff);
   endtask

   task automatic test_directed_cases;
      drain_fill();
      load_fill_cfg(make_cfg(64'h8040_2010_0804_0201, 0, 4095, 0, 4095, 7, 7, ROP_COPY));
      send_byte(9'd511, 12'd4095, 8'h00);
      send_byte(9'd511, 12'd4095, 8'hff);
      send_byte(9'd0, 12'd0, 8'ha5);
      drain_fill();
      load_fill_cfg(make_cfg('1, 10, 13, 5, 5, 0, 0, ROP_OR));
      send_byte(9'd1, 12'd5, 8'h00);
      send_byte(9'd0, 12'd5, 8'h00);
      send_byte(9'd2, 12'd5, 8'h00);
      send_byte(9'd1, 12'd4, 8'h00);
      drain_fill();
      load_fill_cfg(make_cfg(64'hf0f0_3c3c_0f0f_c3c3, 3, 15, 100, 200, 2, 1, ROP_XOR));
      send_byte(9'd0, 12'd100, 8'h5a);
      send_byte(9'd1, 12'd150, 8'h5a);
      send_byte(9'd2, 12'd200, 8'h5a);
      send_byte(9'd3, 12'd150, 8'h5a);
      drain_fill();
      load_fill_cfg(make_cfg(64'h0123_4567_89ab_cdef, 17, 42, 4000, 4095, 3, 5, ROP_CLEAR));
      send_byte(9'd2, 12'd4000, 8'hff);
      send_byte(9'd3, 12'd4095, 8'hff);
      send_byte(9'd5, 12'd4050, 8'hff);
      send_byte(9'd2, 12'd3999, 8'hff);
      drain_fill();
      load_fill_cfg(make_cfg('1, 100, 99, 0, 4095, 0, 0, ROP_OR));
      send_byte(9'd12, 12'd0, 8'h5a);
      drain_fill();
      load_fill_cfg(make_cfg('1, 0, 4095, 10, 9, 0, 0, ROP_OR));
      send_byte(9'd0, 12'd10, 8'h5a);
   endtask

   task automatic test_random_fills;
      fill_cfg_type c;
      int l, r, t, b, count, col_lo, col_hi, row_lo, row_hi;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [BYTE_W-1:0] old;
      while (bytes_sent < RANDOM_ITEMS) begin
         drain_fill();
         if (settings_used == 7) begin
            c = make_cfg('1, 4095, 4095, 4095, 4095, 7, 7, ROP_OR);
         end else if (settings_used == 8) begin
            c = make_cfg('0, 0, 0, 0, 0, 0, 0, ROP_COPY);
         end else begin
            random_span(l, r, 200);
            random_span(t, b, 64);
            c = make_cfg({$urandom(), $urandom()}, l, r, t, b, $urandom_range(0, 7),
                         $urandom_range(0, 7), rop_type'($urandom_range(0, 3)));
            if ($urandom_range(0, 5) == 0) c.pattern = '0;
            else if ($urandom_range(0, 5) == 0) c.pattern = '1;
         end
         load_fill_cfg(c);
         l = (c.left < c.right) ? int'(c.left) : int'(c.right);
         r = (c.left < c.right) ? int'(c.right) : int'(c.left);
         t = (c.top < c.bottom) ? int'(c.top) : int'(c.bottom);
         b = (c.top < c.bottom) ? int'(c.bottom) : int'(c.top);
         col_lo = (l >> 3) > 0 ? (l >> 3) - 1 : 0;
         col_hi = ((r + 1) >> 3) < 511 ? ((r + 1) >> 3) + 1 : 511;
         row_lo = t > 2 ? t - 2 : 0;
         row_hi = b < 4093 ? b + 2 : 4095;
         count  = $urandom_range(30, 90);
         repeat (count) begin
            if ($urandom_range(0, 4) == 0) begin
               col = COL_W'($urandom_range(0, 511));
               row = ROW_W'($urandom_range(0, 4095));
            end else begin
               col = COL_W'($urandom_range(col_lo, col_hi));
               row = ROW_W'($urandom_range(row_lo, row_hi));
            end
            case ($urandom_range(0, 9))
               0:       old = 8'h00;
               1:       old = 8'hff;
               default: old = BYTE_W'($urandom_range(0, 255));
            endcase
            send_byte(col, row, old);
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style <= 2'($urandom_range(0, 3));
         stall_left  <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_tick <= stall_tick + 1;
      case (stall_style)
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_tready <= (stall_tick[1:0] == 2'd0);
         default: rsp_tready <= stall_tick[3];
      endcase
   end

   always @(posedge clock) begin : check_results
      fill_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual new_byte %02h touched %0b",
                     $time, rsp_tdata, rsp_tuser[0]);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            results_checked++;
            if (want.touched) touched_count++;
            if (rsp_tdata !== want.new_byte) begin
               $display("%0t: new_byte mismatch: expected %02h, actual %02h",
                        $time, want.new_byte, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser[0] !== want.touched) begin
               $display("%0t: touched mismatch: expected %0b, actual %0b",
                        $time, want.touched, rsp_tuser[0]);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= IDLE_LIMIT);
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_cases();
      test_random_fills();
      drain_fill();
      $display("Sent %0d byte transactions under %0d register settings.",
               bytes_sent, settings_used);
      $display("Checked %0d results, %0d of them inside the fill mask.",
               results_checked, touched_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/mprf_pkg.sv
design/mono_pattern_rect_fill_rop_top.sv
design/mprf_checker.sv
test/testbench.sv
